// ===== design/slpg_pkg.sv =====
// Shared constants for the status LED pattern generator.
`default_nettype none

package slpg_pkg;

   localparam int unsigned CommandWidth = 2;
   localparam int unsigned ModeWidth    = 3;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned TimeWidth    = 16;
   localparam int unsigned BootWidth    = 15;
   localparam int unsigned PhaseWidth   = 17;

   localparam logic [CommandWidth-1:0] CMD_TICK  = 2'd0;
   localparam logic [CommandWidth-1:0] CMD_MODE  = 2'd1;
   localparam logic [CommandWidth-1:0] CMD_PULSE = 2'd2;

   localparam logic [ModeWidth-1:0] MODE_NORMAL  = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_COMMAND = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_WARNING = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_FAULT   = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_BOOTING = 3'd4;

   localparam logic [CsrIdxWidth-1:0] CSR_ACTIVE_HIGH    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_TX_PULSE       = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_WARNING_PERIOD = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_WARNING_ON     = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_BOOT_HALF      = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_FAULT_PERIOD   = 3'd5;

   localparam logic                 RST_ACTIVE_HIGH    = 1'b1;
   localparam logic [TimeWidth-1:0] RST_TX_PULSE       = 16'd100;
   localparam logic [TimeWidth-1:0] RST_WARNING_PERIOD = 16'd1000;
   localparam logic [TimeWidth-1:0] RST_WARNING_ON     = 16'd500;
   localparam logic [BootWidth-1:0] RST_BOOT_HALF      = 15'd100;
   localparam logic [TimeWidth-1:0] RST_FAULT_PERIOD   = 16'd2000;

   // Fault double flash: lit for [0, 100) and [200, 300).
   localparam logic [PhaseWidth-1:0] FAULT_FLASH_END  = 17'd100;
   localparam logic [PhaseWidth-1:0] FAULT_GAP_END    = 17'd200;
   localparam logic [PhaseWidth-1:0] FAULT_SECOND_END = 17'd300;

   localparam logic [TimeWidth-1:0] AGE_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ===== design/slpg_if.sv =====
// Handshake interfaces for the request and response channels.
`default_nettype none

interface slpg_req_if
   import slpg_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [CommandWidth-1:0] command;
   logic [ModeWidth-1:0]    new_mode;

   modport source (output valid, output command, output new_mode, input ready);
   modport sink   (input valid, input command, input new_mode, output ready);
endinterface

interface slpg_rsp_if
   import slpg_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 pin_level;
   logic [ModeWidth-1:0] current_mode;
   logic                 pulse_showing;

   modport source (output valid, output pin_level, output current_mode,
                   output pulse_showing, input ready);
   modport sink   (input valid, input pin_level, input current_mode,
                   input pulse_showing, output ready);
endinterface

`default_nettype wire

// ===== design/status_led_pattern_generator.sv =====
// Top level of the status LED pattern generator.
// Every request beat (tick, mode change or transmit pulse) updates the pattern state
// in the cycle it is accepted and yields exactly one response beat in the next cycle,
// held in an output register. One beat per cycle is sustained: a new request is
// taken whenever the output register is empty or is being drained in the same cycle,
// so the only limit is the response sink's ready. Configuration writes take effect
// at the next clock edge and should only be made while no response is pending.
`default_nettype none

module status_led_pattern_generator
   import slpg_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   slpg_req_if.sink                     req_bus,
   slpg_rsp_if.source                   rsp_bus,
   input  wire logic                    csr_wr_en,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_wdata
);

   logic                  active_high_ff;
   logic [TimeWidth-1:0]  tx_pulse_ff;
   logic [TimeWidth-1:0]  warn_period_ff;
   logic [TimeWidth-1:0]  warn_on_ff;
   logic [BootWidth-1:0]  boot_half_ff;
   logic [TimeWidth-1:0]  fault_period_ff;

   logic [ModeWidth-1:0]  mode_ff,  mode_in;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic                  pulse_active_ff, pulse_active_in;
   logic [TimeWidth-1:0]  pulse_age_ff, pulse_age_in;

   logic                  rsp_valid_ff;
   logic                  pin_ff, pin_in;
   logic [ModeWidth-1:0]  rsp_mode_ff;
   logic                  showing_ff, showing_in;

   logic                  req_accept;
   logic [PhaseWidth-1:0] period;
   logic [PhaseWidth:0]   phase_next;
   logic                  pattern_lit;
   logic                  lit;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff  <= RST_ACTIVE_HIGH;
         tx_pulse_ff     <= RST_TX_PULSE;
         warn_period_ff  <= RST_WARNING_PERIOD;
         warn_on_ff      <= RST_WARNING_ON;
         boot_half_ff    <= RST_BOOT_HALF;
         fault_period_ff <= RST_FAULT_PERIOD;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACTIVE_HIGH:    active_high_ff  <= csr_wdata[0];
            CSR_TX_PULSE:       tx_pulse_ff     <= csr_wdata[TimeWidth-1:0];
            CSR_WARNING_PERIOD: warn_period_ff  <= csr_wdata[TimeWidth-1:0];
            CSR_WARNING_ON:     warn_on_ff      <= csr_wdata[TimeWidth-1:0];
            CSR_BOOT_HALF:      boot_half_ff    <= csr_wdata[BootWidth-1:0];
            CSR_FAULT_PERIOD:   fault_period_ff <= csr_wdata[TimeWidth-1:0];
            default: ;
         endcase
      end
   end

   // Pattern period of the mode in force before this beat; zero acts as one.
   always_comb begin
      case (mode_ff)
         MODE_WARNING: period = {1'b0, warn_period_ff};
         MODE_FAULT:   period = {1'b0, fault_period_ff};
         MODE_BOOTING: period = {1'b0, boot_half_ff, 1'b0};
         default:      period = PhaseWidth'(1);
      endcase
      if (period == '0) begin
         period = PhaseWidth'(1);
      end
   end

   assign phase_next = {1'b0, phase_ff} + (PhaseWidth+1)'(1);

   always_comb begin
      mode_in         = mode_ff;
      phase_in        = phase_ff;
      pulse_active_in = pulse_active_ff;
      pulse_age_in    = pulse_age_ff;
      case (req_bus.command)
         CMD_TICK: begin
            if (pulse_age_ff != AGE_MAX) begin
               pulse_age_in = pulse_age_ff + TimeWidth'(1);
            end
            phase_in = (phase_next >= {1'b0, period}) ? '0 : phase_next[PhaseWidth-1:0];
         end
         CMD_MODE: begin
            if (req_bus.new_mode != mode_ff) begin
               mode_in  = req_bus.new_mode;
               phase_in = '0;
            end
         end
         CMD_PULSE: begin
            pulse_active_in = 1'b1;
            pulse_age_in    = '0;
         end
         default: ;
      endcase

      showing_in = 1'b0;
      if (pulse_active_in && mode_in != MODE_WARNING && mode_in != MODE_FAULT) begin
         if (pulse_age_in < tx_pulse_ff) begin
            showing_in = 1'b1;
         end else begin
            pulse_active_in = 1'b0;
         end
      end
   end

   // Pattern level from the updated mode and phase.
   always_comb begin
      case (mode_in)
         MODE_COMMAND: pattern_lit = 1'b1;
         MODE_WARNING: pattern_lit = phase_in < {1'b0, warn_on_ff};
         MODE_FAULT:   pattern_lit = (phase_in < FAULT_FLASH_END)
                                     || (phase_in >= FAULT_GAP_END
                                         && phase_in < FAULT_SECOND_END);
         MODE_BOOTING: pattern_lit = phase_in < {2'b00, boot_half_ff};
         default:      pattern_lit = 1'b0;
      endcase
   end

   assign lit    = showing_in || pattern_lit;
   assign pin_in = lit ^ !active_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_BOOTING;
         phase_ff        <= '0;
         pulse_active_ff <= 1'b0;
         pulse_age_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            mode_ff         <= mode_in;
            phase_ff        <= phase_in;
            pulse_active_ff <= pulse_active_in;
            pulse_age_ff    <= pulse_age_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff    <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pin_ff      <= pin_in;
         rsp_mode_ff <= mode_in;
         showing_ff  <= showing_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pin_level     = pin_ff;
   assign rsp_bus.current_mode  = rsp_mode_ff;
   assign rsp_bus.pulse_showing = showing_ff;

endmodule

`default_nettype wire

// ===== design/slpg_checker.sv =====
// Port-level assertions for the status LED pattern generator, bound to the top level.
`default_nettype none

module slpg_checker
   import slpg_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_pin_level,
   input wire logic [ModeWidth-1:0] rsp_current_mode,
   input wire logic                 rsp_pulse_showing
);

   // Nothing is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every accepted request beat shows up as a response beat in the next cycle.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no response");

   // The transmit override never shows in warning or fault mode.
   a_no_pulse_in_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_current_mode == MODE_WARNING || rsp_current_mode == MODE_FAULT))
      |-> !rsp_pulse_showing)
      else $error("pulse override shown in warning or fault mode");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pin_level)
         && $stable(rsp_current_mode) && $stable(rsp_pulse_showing)))
      else $error("stalled response beat changed");

endmodule

bind status_led_pattern_generator slpg_checker u_slpg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_pin_level     (rsp_bus.pin_level),
   .rsp_current_mode  (rsp_bus.current_mode),
   .rsp_pulse_showing (rsp_bus.pulse_showing)
);

`default_nettype wire
